// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define MLT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Clocked assertion that also holds during reset.
`define MLT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

// ----- rtl/mlt_pkg.sv -----
// Shared constants for the motion lock trigger: item kinds, trigger modes,
// register indexes and the packing of the request and response beats.
package mlt_pkg;

   // item kinds carried in req_tuser
   localparam logic [1:0] KIND_SENSOR = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_TEST   = 2'd2;

   // trigger modes
   localparam logic [1:0] TRIG_MOMENTARY = 2'd0;
   localparam logic [1:0] TRIG_TOGGLE    = 2'd1;
   localparam logic [1:0] TRIG_LATCH     = 2'd2;

   localparam logic [1:0] MASK_BOTH = 2'd3;

   // alert lane codes
   localparam logic [1:0] LANE_BOTH = 2'd0;
   localparam logic [1:0] LANE_ONE  = 2'd1;
   localparam logic [1:0] LANE_TWO  = 2'd2;

   localparam logic [1:0] ALERT_OFF = 2'd0;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_MODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_MASK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REARM_DELAY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_TARGET = 3'd4;
   localparam int CSR_DATA_W = 16;

   localparam int COUNT_W = 16;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;

   // response field positions in rsp_tdata
   localparam int RSP_CMD_VALID_BIT = 0;
   localparam int RSP_ALERT_FIRE_BIT = 4;
   localparam int RSP_MOTION_BIT = 9;

   typedef struct packed {
      logic       motion_present;
      logic [1:0] alert_dest;
      logic [1:0] alert_lane;
      logic       alert_fire;
      logic       lock_arm;
      logic [1:0] lock_select;
      logic       lock_cmd_valid;
   } rsp_fields_type;

endpackage

// ----- rtl/motion_lock_trigger_rearm_top.sv -----
// Motion lock trigger with automatic re-arm, top level.
// Depends on mlt_pkg.
//
// Usage:
//   req channel: one beat per item. req_tuser holds the item kind (sensor
//   sample, one-second tick, test request), req_tdata[0] the raw active-low
//   sensor pin. Every accepted beat yields exactly one rsp beat.
//   rsp channel: lock command, alert request and the current motion flag.
//   csr port: csr_we writes csr_wdata to register csr_index;
//   write only while no item is in flight.
// Result: an accepted beat's result is written to the result register and
//   shown on rsp the next cycle.
// Throughput: one item per cycle; req_tready stays high while the result
//   register is empty or is being drained in the same cycle.
// Stall: when rsp_tready is low with a beat held, req_tready drops and the
//   held beat stays unchanged.
// Reset: synchronous, active high; registers return to their defaults
//   (enabled, momentary, lock one, delay 4, alert target 3), channel state
//   clears and the result register empties.
module motion_lock_trigger_rearm_top
   import mlt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [0] pin_level, rest zero
   input  logic [REQ_USER_W-1:0]  req_tuser,   // [1:0] item kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] lock_cmd_valid, [2:1] lock_select, [3] lock_arm, [4] alert_fire,
   // [6:5] alert_lane, [8:7] alert_dest, [9] motion_present, rest zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FIELDS_W = $bits(rsp_fields_type);

   logic               enable_ff, enable_in;
   logic [1:0]         trig_mode_ff, trig_mode_in;
   logic [1:0]         lock_mask_ff, lock_mask_in;
   logic [COUNT_W-1:0] rearm_delay_ff, rearm_delay_in;
   logic [1:0]         alert_target_ff, alert_target_in;

   logic               prev_present_ff, prev_present_in;
   logic               present_now_ff, present_now_in;
   logic               toggle_armed_ff, toggle_armed_in;
   logic [COUNT_W-1:0] tick_count_ff, tick_count_in;
   logic               timer_done_ff, timer_done_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_fields_type     rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               present_smp;
   logic               do_edge;
   logic               latch_arm;
   logic               do_issue;
   logic               issue_arm;
   logic               issue_alert;
   logic [1:0]         mode_wr;
   rsp_fields_type     fields;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign present_smp = !req_tdata[0];

   always_comb begin
      enable_in       = enable_ff;
      trig_mode_in    = trig_mode_ff;
      lock_mask_in    = lock_mask_ff;
      rearm_delay_in  = rearm_delay_ff;
      alert_target_in = alert_target_ff;
      prev_present_in = prev_present_ff;
      present_now_in  = present_now_ff;
      toggle_armed_in = toggle_armed_ff;
      tick_count_in   = tick_count_ff;
      timer_done_in   = timer_done_ff;
      do_edge         = 1'b0;
      latch_arm       = 1'b1;
      do_issue        = 1'b0;
      issue_arm       = 1'b0;
      issue_alert     = 1'b0;
      mode_wr         = csr_wdata[1:0];

      if (accept) begin
         case (req_tuser)
            KIND_SENSOR: begin
               present_now_in  = present_smp;
               prev_present_in = present_smp;
               latch_arm       = present_smp;
               if (enable_ff) begin
                  if (trig_mode_ff == TRIG_LATCH)
                     do_edge = present_smp != prev_present_ff;
                  else
                     do_edge = present_smp && !prev_present_ff;
               end
            end
            KIND_TICK: begin
               if (tick_count_ff >= rearm_delay_ff && !timer_done_ff) begin
                  do_issue      = 1'b1;
                  issue_arm     = 1'b1;
                  timer_done_in = 1'b1;
               end else if (tick_count_ff != {COUNT_W{1'b1}}) begin
                  tick_count_in = tick_count_ff + 1'b1;
               end
            end
            KIND_TEST: do_edge = 1'b1;
            default: ;
         endcase

         if (do_edge) begin
            do_issue    = 1'b1;
            issue_alert = 1'b1;
            if (trig_mode_ff == TRIG_LATCH) begin
               issue_arm     = latch_arm;
               timer_done_in = 1'b1;
            end else if (trig_mode_ff == TRIG_TOGGLE) begin
               toggle_armed_in = !toggle_armed_ff;
               issue_arm       = !toggle_armed_ff;
               timer_done_in   = 1'b1;
            end else begin
               issue_arm     = 1'b0;
               tick_count_in = '0;
               timer_done_in = 1'b0;
            end
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE: enable_in = csr_wdata[0];
            CSR_TRIGGER_MODE: begin
               // code 3 keeps latch, otherwise falls back to momentary
               if (mode_wr == 2'd3)
                  mode_wr = (trig_mode_ff == TRIG_LATCH) ? TRIG_LATCH : TRIG_MOMENTARY;
               if (mode_wr != TRIG_TOGGLE)
                  toggle_armed_in = 1'b0;
               trig_mode_in = mode_wr;
            end
            CSR_LOCK_MASK: begin
               if (csr_wdata[1:0] != 2'd0)
                  lock_mask_in = csr_wdata[1:0];
            end
            CSR_REARM_DELAY:  rearm_delay_in  = csr_wdata[COUNT_W-1:0];
            CSR_ALERT_TARGET: alert_target_in = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      fields = '0;
      fields.motion_present = present_now_in;
      if (do_issue) begin
         fields.lock_cmd_valid = 1'b1;
         fields.lock_select    = lock_mask_ff;
         fields.lock_arm       = issue_arm;
         if (issue_alert && alert_target_ff != ALERT_OFF) begin
            fields.alert_fire = 1'b1;
            fields.alert_dest = alert_target_ff;
            if (lock_mask_ff == MASK_BOTH)
               fields.alert_lane = LANE_BOTH;
            else if (lock_mask_ff[0])
               fields.alert_lane = LANE_ONE;
            else
               fields.alert_lane = LANE_TWO;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fields;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b1;
         trig_mode_ff    <= TRIG_MOMENTARY;
         lock_mask_ff    <= 2'd1;
         rearm_delay_ff  <= COUNT_W'(4);
         alert_target_ff <= 2'd3;
         prev_present_ff <= 1'b0;
         present_now_ff  <= 1'b0;
         toggle_armed_ff <= 1'b0;
         tick_count_ff   <= '0;
         timer_done_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         enable_ff       <= enable_in;
         trig_mode_ff    <= trig_mode_in;
         lock_mask_ff    <= lock_mask_in;
         rearm_delay_ff  <= rearm_delay_in;
         alert_target_ff <= alert_target_in;
         prev_present_ff <= prev_present_in;
         present_now_ff  <= present_now_in;
         toggle_armed_ff <= toggle_armed_in;
         tick_count_ff   <= tick_count_in;
         timer_done_ff   <= timer_done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-FIELDS_W){1'b0}}, rsp_data_ff};

endmodule

// ----- rtl/mlt_checker.sv -----
// Port-level checks for motion_lock_trigger_rearm_top, bound to the top.
// Depends on mlt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mlt_checker
   import mlt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a held response beat does not change
   `MLT_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))

   // every accepted request shows a response the next cycle
   `MLT_ASSERT(a_req_to_rsp, clock, reset, (req_tvalid && req_tready) |=> rsp_tvalid)

   // an empty result register never back-pressures the request side
   `MLT_ASSERT(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)

   // a sensor beat's motion flag is the inverted pin
   `MLT_ASSERT(a_motion_follows_pin, clock, reset, (req_tvalid && req_tready && req_tuser == KIND_SENSOR) |=> (rsp_tdata[RSP_MOTION_BIT] == !$past(req_tdata[0])))

   // no response beat right after reset
   `MLT_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_tvalid)

endmodule

bind motion_lock_trigger_rearm_top mlt_checker u_mlt_checker (.*);
